// ===== rtl/token_bucket_shaper_top_macros.svh =====
// Assertion macros shared by the RTL files of the token bucket shaper.
// IMPLY checks a consequence in the same cycle, NEXT checks it in the cycle after.
`ifndef TOKEN_BUCKET_SHAPER_TOP_MACROS_SVH
`define TOKEN_BUCKET_SHAPER_TOP_MACROS_SVH

`ifndef SYNTH
`define TBS_ASSERT_IMPLY(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("token bucket shaper check failed");
`define TBS_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("token bucket shaper check failed");
`else
`define TBS_ASSERT_IMPLY(name, clk, rst, pre, post)
`define TBS_ASSERT_NEXT(name, clk, rst, pre, post)
`endif

`endif

// ===== rtl/tbs_pkg.sv =====
`default_nettype none

package tbs_pkg;

   // One input transaction: a packet arrival or a token tick.
   typedef struct packed {
      logic        mode;
      logic [15:0] packet_id;
      logic [15:0] tokens_needed;
   } req_type;

   // One result transaction.
   typedef struct packed {
      logic [2:0]  event_code;
      logic [15:0] packet_ref;
      logic [15:0] bucket_now;
      logic [4:0]  waiting_now;
      logic        last;
   } rsp_type;

   localparam logic MODE_ARRIVAL = 1'b0;
   localparam logic MODE_TICK    = 1'b1;

   localparam logic [2:0] EV_QUEUED        = 3'd0;
   localparam logic [2:0] EV_FORWARDED     = 3'd1;
   localparam logic [2:0] EV_TOO_LARGE     = 3'd2;
   localparam logic [2:0] EV_QUEUE_FULL    = 3'd3;
   localparam logic [2:0] EV_TOKEN_ADDED   = 3'd4;
   localparam logic [2:0] EV_TOKEN_DROPPED = 3'd5;

   // Register index as decoded from the word address.
   localparam logic REG_BUCKET_DEPTH = 1'b0;

   localparam logic [15:0] BUCKET_DEPTH_RESET = 16'd10;

   typedef enum logic {
      ST_IDLE,
      ST_DECIDE
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/token_bucket_shaper_top.sv =====
// Channel   Direction  Payload                               Handshake
// req       in         tbs_pkg::req_type (mode, id, need)    req_valid / req_ready
// rsp       out        tbs_pkg::rsp_type (event, ref, ...)   rsp_valid / rsp_ready
// csr       in/out     bucket_depth at byte address 0        APB psel/penable, pready=1
//
// An arrival transaction gives one result. A tick first updates the bucket and
// moves to the decide state, which gives its token result and then one result
// for every packet it releases, as the result register frees up; the read port
// follows the next head, so the new head entry is ready as soon as the head moves.
// Reset is synchronous: it empties the queue, zeroes the bucket and sets the
// depth to 10. The queue memory is not cleared, since no entry is read before
// it is written. A stalled result register blocks new work until it drains.
`default_nettype none

`include "token_bucket_shaper_top_macros.svh"

module token_bucket_shaper_top #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,

   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire tbs_pkg::req_type req_data,

   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output tbs_pkg::rsp_type      rsp_data,

   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [2:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   import tbs_pkg::*;

   // Pointer and count widths follow from the queue depth.
   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   // Pointer increment with wrap at the last entry of the queue.
   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
      return (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

   // Control and bucket state.
   state_type        state_ff, state_in;
   logic [15:0]      depth_ff, depth_in;
   logic [15:0]      level_ff, level_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // A tick's token result or a forwarded result waits here until it is known
   // whether another packet follows it, since only the final one carries last.
   rsp_type          pend_ff, pend_in;

   // Output register separating the core from the result channel.
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   // The waiting queue: entry holds the id in the high half, the need in the
   // low half. The read port always follows the next head pointer, and a write
   // to that same entry is forwarded, so rd_data_ff always holds the current
   // head entry.
   logic [31:0]      queue_mem [QUEUE_DEPTH];
   logic [31:0]      rd_data_ff;
   logic             mem_we;
   logic [31:0]      mem_wdata;

   logic             out_free;
   logic             fwd_more;
   logic             csr_write;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The head packet can be released when there is one and the bucket covers it.
   assign fwd_more = (count_ff != '0) && (level_ff >= rd_data_ff[15:0]);

   // Configuration port. Only the bucket depth exists; other indexes read zero.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_BUCKET_DEPTH) ? {16'h0, depth_ff} : 32'h0;
   assign depth_in   = (csr_write && (csr_paddr[2] == REG_BUCKET_DEPTH)) ?
                       csr_pwdata[15:0] : depth_ff;

   assign mem_wdata  = {req_data.packet_id, req_data.tokens_needed};

   always_comb begin
      logic [15:0]      lvl;
      logic [CNT_W-1:0] cnt;
      lvl = level_ff;
      cnt = count_ff;

      state_in     = state_ff;
      level_in     = level_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      pend_in      = pend_ff;
      mem_we       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               if (req_data.mode == MODE_TICK) begin
                  // Token result is held back until the release check is done.
                  if (level_ff < depth_ff) begin
                     lvl                = level_ff + 16'd1;
                     pend_in.event_code = EV_TOKEN_ADDED;
                  end else begin
                     pend_in.event_code = EV_TOKEN_DROPPED;
                  end
                  level_in            = lvl;
                  pend_in.packet_ref  = 16'h0;
                  pend_in.bucket_now  = lvl;
                  pend_in.waiting_now = 5'(count_ff);
                  pend_in.last        = 1'b0;
                  state_in            = ST_DECIDE;
               end else begin
                  rsp_valid_in           = 1'b1;
                  rsp_data_in.packet_ref = req_data.packet_id;
                  rsp_data_in.last       = 1'b1;
                  if (req_data.tokens_needed > depth_ff) begin
                     rsp_data_in.event_code = EV_TOO_LARGE;
                  end else if (count_ff == FULL_CNT) begin
                     rsp_data_in.event_code = EV_QUEUE_FULL;
                  end else begin
                     mem_we  = 1'b1;
                     tail_in = next_idx(tail_ff);
                     if ((count_ff == '0) && (level_ff >= req_data.tokens_needed)) begin
                        // Alone in the queue and covered: it passes straight through.
                        lvl                    = level_ff - req_data.tokens_needed;
                        head_in                = next_idx(head_ff);
                        rsp_data_in.event_code = EV_FORWARDED;
                     end else begin
                        cnt                    = count_ff + 1'b1;
                        rsp_data_in.event_code = EV_QUEUED;
                     end
                  end
                  level_in                = lvl;
                  count_in                = cnt;
                  rsp_data_in.bucket_now  = lvl;
                  rsp_data_in.waiting_now = 5'(cnt);
               end
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_data_in      = pend_ff;
               rsp_data_in.last = !fwd_more;
               if (fwd_more) begin
                  lvl                 = level_ff - rd_data_ff[15:0];
                  cnt                 = count_ff - 1'b1;
                  level_in            = lvl;
                  count_in            = cnt;
                  head_in             = next_idx(head_ff);
                  pend_in.event_code  = EV_FORWARDED;
                  pend_in.packet_ref  = rd_data_ff[31:16];
                  pend_in.bucket_now  = lvl;
                  pend_in.waiting_now = 5'(cnt);
                  pend_in.last        = 1'b0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         depth_ff     <= BUCKET_DEPTH_RESET;
         level_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         level_ff     <= level_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Queue memory: one write port at the tail, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         queue_mem[tail_ff] <= mem_wdata;
      end
      if (mem_we && (tail_ff == head_in)) begin
         rd_data_ff <= mem_wdata;
      end else begin
         rd_data_ff <= queue_mem[head_in];
      end
   end

   `TBS_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= FULL_CNT)
   `TBS_ASSERT_IMPLY(a_empty_ptrs, clock, reset, count_ff == '0, head_ff == tail_ff)
   `TBS_ASSERT_NEXT(a_tick_decide, clock, reset,
                    req_valid && req_ready && (req_data.mode == MODE_TICK),
                    state_ff == ST_DECIDE)
   `TBS_ASSERT_NEXT(a_release_pays, clock, reset,
                    (state_ff == ST_DECIDE) && out_free && fwd_more,
                    level_ff == $past(level_ff - rd_data_ff[15:0]))

endmodule

`default_nettype wire
